>>> hdl/owrid_pkg.sv
// ----------------------------------------------------------------------------
// owrid_pkg
// Shared codes and helpers for the 1-Wire ROM id text parser: parse phases,
// result status codes, hex digit decode and the bytewise 1-Wire CRC8.
// ----------------------------------------------------------------------------
`default_nettype none

package owrid_pkg;

  // parse phase codes
  localparam logic [2:0] PH_FAM     = 3'd0;
  localparam logic [2:0] PH_FAMDONE = 3'd1;
  localparam logic [2:0] PH_ID      = 3'd2;
  localparam logic [2:0] PH_IDDONE  = 3'd3;
  localparam logic [2:0] PH_DOT2    = 3'd4;
  localparam logic [2:0] PH_CRC     = 3'd5;
  localparam logic [2:0] PH_DONE    = 3'd6;

  // result status codes
  typedef enum logic [1:0] {
    STAT_VALID    = 2'd0,
    STAT_FORMAT   = 2'd1,
    STAT_MISMATCH = 2'd2
  } status_e;

  // id field length in hex digits
  localparam logic [3:0] ID_DIGITS = 4'd12;

  localparam logic [7:0] CHAR_DOT = 8'h2E;

  // reflected 1-Wire polynomial
  localparam logic [7:0] CRC_POLY = 8'h8C;

  typedef struct packed {
    logic       ok;
    logic [3:0] nib;
  } hex_t;

  // ascii hex digit decode, both letter cases
  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t r;
    r.ok  = 1'b1;
    r.nib = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.nib = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.nib = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.nib = 4'(c - 8'h37);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  // one byte of crc8, lsb first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> hdl/onewire_rom_id_text_parser_core.sv
// ----------------------------------------------------------------------------
// onewire_rom_id_text_parser_core
// Parses a 1-Wire serial number written as hex text (family, optional dot,
// twelve id digits, optional dot, optional crc digits), builds the seven
// bytes, runs the 1-Wire CRC8 and reports one result per string.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+------------------------------
//   in      | sink      | in_valid_i / in_ready_o   | char_code_i, last_char_i
//   out     | source    | out_valid_o / out_ready_i | status_o, family_code_o,
//           |           |                           | device_id_o, crc_byte_o
//
// One character is taken per cycle; the parse state updates in the cycle of
// the beat. A last character loads the result register, so its result shows
// in the next cycle. While a result waits and out_ready_i is low, in_ready_o
// is low; when the result is taken the same cycle can accept the next character.
// Reset (rst_ni low, asynchronous) returns the parser to the family field
// start and empties the result register.
`default_nettype none

module onewire_rom_id_text_parser_core (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [7:0]             char_code_i,
  input  wire logic                   last_char_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output owrid_pkg::status_e          status_o,
  output logic [7:0]                  family_code_o,
  output logic [47:0]                 device_id_o,
  output logic [7:0]                  crc_byte_o
);

  import owrid_pkg::*;

  logic [2:0]  phase_q, phase_d;
  logic [3:0]  dc_q, dc_d;
  logic [3:0]  nib_q, nib_d;
  logic [55:0] ser_q, ser_d;
  logic [7:0]  crc_q, crc_d;
  logic [7:0]  given_q, given_d;
  logic        ferr_q, ferr_d;

  logic        out_valid_q;
  status_e     status_q, status_d;
  logic [7:0]  fam_q;
  logic [47:0] id_q;
  logic [7:0]  crcb_q;

  hex_t        hx;
  logic        is_dot;
  logic [7:0]  byte_v;
  logic [2:0]  idx;
  logic        in_beat;
  logic        complete;
  logic        res_ok;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_beat    = in_valid_i && in_ready_o;

  // character decode
  assign hx     = hex_decode(char_code_i);
  assign is_dot = (char_code_i == CHAR_DOT);
  assign byte_v = {nib_q, hx.nib};
  assign idx    = 3'((dc_q + 4'd1) >> 1);

  // phase machine, next state for this character
  always_comb begin
    phase_d = phase_q;
    dc_d    = dc_q;
    nib_d   = nib_q;
    ser_d   = ser_q;
    crc_d   = crc_q;
    given_d = given_q;
    ferr_d  = ferr_q;
    if (!ferr_q) begin
      unique case (phase_q) inside
        PH_FAM: begin
          if (!hx.ok) begin
            ferr_d = 1'b1;
          end else if (dc_q == 4'd0) begin
            nib_d = hx.nib;
            dc_d  = 4'd1;
          end else begin
            ser_d[7:0] = byte_v;
            crc_d      = crc8_byte(crc_q, byte_v);
            dc_d       = 4'd0;
            phase_d    = PH_FAMDONE;
          end
        end
        PH_FAMDONE: begin
          if (is_dot) begin
            phase_d = PH_ID;
            dc_d    = 4'd0;
          end else if (!hx.ok) begin
            ferr_d = 1'b1;
          end else begin
            nib_d   = hx.nib;
            dc_d    = 4'd1;
            phase_d = PH_ID;
          end
        end
        PH_ID: begin
          if (!hx.ok || dc_q >= ID_DIGITS) begin
            ferr_d = 1'b1;
          end else begin
            if (!dc_q[0]) begin
              nib_d = hx.nib;
            end else begin
              ser_d[idx*8 +: 8] = byte_v;
              crc_d             = crc8_byte(crc_q, byte_v);
            end
            dc_d = dc_q + 4'd1;
            if (dc_q == ID_DIGITS - 4'd1) begin
              phase_d = PH_IDDONE;
              dc_d    = 4'd0;
            end
          end
        end
        PH_IDDONE, PH_DOT2: begin
          if (is_dot && phase_q == PH_IDDONE) begin
            phase_d = PH_DOT2;
          end else if (!hx.ok) begin
            ferr_d = 1'b1;
          end else begin
            nib_d   = hx.nib;
            phase_d = PH_CRC;
          end
        end
        PH_CRC: begin
          if (!hx.ok) begin
            ferr_d = 1'b1;
          end else begin
            given_d = byte_v;
            phase_d = PH_DONE;
          end
        end
        default: begin
          ferr_d = 1'b1;
        end
      endcase
    end
  end

  // result status
  assign complete = (phase_d == PH_IDDONE) || (phase_d == PH_DOT2) || (phase_d == PH_DONE);
  assign res_ok   = !ferr_d && complete;

  always_comb begin
    if (!res_ok) begin
      status_d = STAT_FORMAT;
    end else if (phase_d == PH_DONE && given_d != crc_d) begin
      status_d = STAT_MISMATCH;
    end else begin
      status_d = STAT_VALID;
    end
  end

  // parse state, cleared after the last character of a string
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FAM;
      dc_q    <= 4'd0;
      nib_q   <= 4'd0;
      ser_q   <= '0;
      crc_q   <= 8'd0;
      given_q <= 8'd0;
      ferr_q  <= 1'b0;
    end else if (in_beat) begin
      if (last_char_i) begin
        phase_q <= PH_FAM;
        dc_q    <= 4'd0;
        nib_q   <= 4'd0;
        ser_q   <= '0;
        crc_q   <= 8'd0;
        given_q <= 8'd0;
        ferr_q  <= 1'b0;
      end else begin
        phase_q <= phase_d;
        dc_q    <= dc_d;
        nib_q   <= nib_d;
        ser_q   <= ser_d;
        crc_q   <= crc_d;
        given_q <= given_d;
        ferr_q  <= ferr_d;
      end
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_beat && last_char_i) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_beat && last_char_i) begin
      status_q <= status_d;
      fam_q    <= res_ok ? ser_d[7:0]  : 8'd0;
      id_q     <= res_ok ? ser_d[55:8] : 48'd0;
      crcb_q   <= res_ok ? crc_d       : 8'd0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign family_code_o = fam_q;
  assign device_id_o   = id_q;
  assign crc_byte_o    = crcb_q;

`ifndef SYNTHESIS
  // a last character always leaves a result behind
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && last_char_i |=> out_valid_o)
    else $error("last character beat did not load a result");

  // the parser starts fresh after each string
  a_last_clears_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && last_char_i |=> (phase_q == PH_FAM) && !ferr_q && (dc_q == 4'd0))
    else $error("parse state not cleared after last character");

  // a format failure carries zeroed fields
  a_format_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STAT_FORMAT |->
      family_code_o == 8'd0 && device_id_o == 48'd0 && crc_byte_o == 8'd0)
    else $error("format failure result with nonzero fields");

  // digit count never passes the id length
  a_dc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dc_q < ID_DIGITS)
    else $error("digit count out of range");
`endif

endmodule

`default_nettype wire

>>> dv/tb_onewire_rom_id_text_parser_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_onewire_rom_id_text_parser_core
// Streams serial number text into the parser one character per beat, with
// bursty input and a stalling output. Every accepted character is fed to a
// behavioral parser that predicts the status, family, id and crc8 for each
// string, and each result beat is compared against the oldest prediction.
// ----------------------------------------------------------------------------

module tb_onewire_rom_id_text_parser_core;
  import owrid_pkg::*;

  localparam int TEXT_CHARS   = 1500;
  localparam int HOLDOFF_LEN  = 300;
  localparam int QUIET_LIMIT  = 3000;
  localparam int SHOWN_ERRORS = 10;

  // one predicted result
  typedef struct packed {
    status_e     status;
    logic [7:0]  family;
    logic [47:0] id;
    logic [7:0]  crc;
  } rom_id_t;

  // tracks the text parse and the queue of predicted ids
  class rom_id_checker;
    typedef enum logic [2:0] {
      S_FAMILY, S_FAMILY_END, S_ID, S_ID_END, S_SEP2, S_CRC, S_CLOSED
    } text_phase_e;

    text_phase_e phase;
    logic [3:0]  ndig;
    logic [3:0]  nib;
    logic [55:0] rom_bytes;
    logic [7:0]  crc_calc;
    logic [7:0]  crc_text;
    logic        bad;
    rom_id_t     pending_ids[$];
    int          errors, strings, chars, results;
    int          n_valid, n_format, n_mismatch;

    function new();
      clear_parse();
    endfunction

    function void clear_parse();
      phase     = S_FAMILY;
      ndig      = '0;
      nib       = '0;
      rom_bytes = '0;
      crc_calc  = '0;
      crc_text  = '0;
      bad       = 1'b0;
    endfunction

    // crc8 over one byte, data bits lsb first
    static function logic [7:0] crc_step(logic [7:0] crc, logic [7:0] d);
      logic [7:0] c;
      logic       fb;
      c = crc;
      for (int i = 0; i < 8; i++) begin
        fb = c[0] ^ d[i];
        c  = c >> 1;
        if (fb) c = c ^ CRC_POLY;
      end
      return c;
    endfunction

    // value of a hex digit, -1 for anything else
    static function int hex_val(logic [7:0] ch);
      if (ch >= "0" && ch <= "9") return ch - "0";
      if (ch >= "a" && ch <= "f") return ch - "a" + 10;
      if (ch >= "A" && ch <= "F") return ch - "A" + 10;
      return -1;
    endfunction

    function void put_byte(int idx, logic [7:0] b);
      rom_bytes[idx*8 +: 8] = b;
      crc_calc = crc_step(crc_calc, b);
    endfunction

    // advance the parse by one character
    function void parse_char(logic [7:0] ch);
      int   v;
      logic is_dot;
      v      = hex_val(ch);
      is_dot = (ch == ".");
      case (phase)
        S_FAMILY: begin
          if (v < 0) bad = 1'b1;
          else if (ndig == 0) begin
            nib  = v[3:0];
            ndig = 4'd1;
          end else begin
            put_byte(0, {nib, v[3:0]});
            ndig  = '0;
            phase = S_FAMILY_END;
          end
        end
        S_FAMILY_END: begin
          if (is_dot) begin
            phase = S_ID;
            ndig  = '0;
          end else if (v < 0) bad = 1'b1;
          else begin
            nib   = v[3:0];
            ndig  = 4'd1;
            phase = S_ID;
          end
        end
        S_ID: begin
          if (v < 0) bad = 1'b1;
          else begin
            if (!ndig[0]) nib = v[3:0];
            else put_byte((int'(ndig) + 1) / 2, {nib, v[3:0]});
            ndig = ndig + 4'd1;
            if (ndig == 4'd12) begin
              phase = S_ID_END;
              ndig  = '0;
            end
          end
        end
        S_ID_END, S_SEP2: begin
          if (is_dot && phase == S_ID_END) phase = S_SEP2;
          else if (v < 0) bad = 1'b1;
          else begin
            nib   = v[3:0];
            phase = S_CRC;
          end
        end
        S_CRC: begin
          if (v < 0) bad = 1'b1;
          else begin
            crc_text = {nib, v[3:0]};
            phase    = S_CLOSED;
          end
        end
        default: bad = 1'b1;
      endcase
    endfunction

    // accepted input beat
    function void note_char(logic [7:0] ch, logic last);
      rom_id_t e;
      chars++;
      if (!bad) parse_char(ch);
      if (last) begin
        if (bad || !(phase inside {S_ID_END, S_SEP2, S_CLOSED})) begin
          e = '{STAT_FORMAT, 8'h00, 48'h0, 8'h00};
        end else begin
          e.status = (phase == S_CLOSED && crc_text != crc_calc) ? STAT_MISMATCH
                                                                  : STAT_VALID;
          e.family = rom_bytes[7:0];
          e.id     = rom_bytes[55:8];
          e.crc    = crc_calc;
        end
        pending_ids.push_back(e);
        strings++;
        clear_parse();
      end
    endfunction

    // accepted output beat
    function void check_result(status_e s, logic [7:0] f, logic [47:0] id,
                               logic [7:0] c);
      rom_id_t e;
      if (pending_ids.size() == 0) begin
        errors++;
        if (errors <= SHOWN_ERRORS)
          $display("error: result with nothing expected: st=%0d fam=%h id=%h crc=%h",
                   s, f, id, c);
        return;
      end
      e = pending_ids.pop_front();
      results++;
      if (s !== e.status || f !== e.family || id !== e.id || c !== e.crc) begin
        errors++;
        if (errors <= SHOWN_ERRORS)
          $display("error: result %0d exp st=%0d fam=%h id=%h crc=%h got st=%0d fam=%h id=%h crc=%h",
                   results, e.status, e.family, e.id, e.crc, s, f, id, c);
      end else begin
        case (s)
          STAT_VALID:    n_valid++;
          STAT_FORMAT:   n_format++;
          STAT_MISMATCH: n_mismatch++;
          default: ;
        endcase
      end
    endfunction

    function int pending();
      return pending_ids.size();
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [7:0]  char_code_i = 8'h00;
  logic        last_char_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  status_e     status_o;
  logic [7:0]  family_code_o;
  logic [47:0] device_id_o;
  logic [7:0]  crc_byte_o;

  rom_id_checker board = new();
  logic [7:0]    text_buf[$];
  int            burst_left;
  int            chars_sent;
  int            holdoff_asked;
  int            holdoff_served;
  int            stall_left;
  int            rx_tick;
  int            rx_mode;
  int            quiet_cycles;

  onewire_rom_id_text_parser_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .char_code_i   (char_code_i),
    .last_char_i   (last_char_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .family_code_o (family_code_o),
    .device_id_o   (device_id_o),
    .crc_byte_o    (crc_byte_o)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // beat monitor, both channels
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) board.note_char(char_code_i, last_char_i);
      if (out_valid_o && out_ready_i)
        board.check_result(status_o, family_code_o, device_id_o, crc_byte_o);
    end
  end

  // watchdog on beats
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                 quiet_cycles, board.pending());
        $display("tb: failure");
        $finish;
      end
    end
  end

  // output stall pattern, plus the long hold-off on request
  always @(negedge clk_i) begin
    rx_tick++;
    if (holdoff_asked != holdoff_served) begin
      holdoff_served = holdoff_asked;
      stall_left     = HOLDOFF_LEN;
    end
    if (rx_tick % 50 == 0) rx_mode = $urandom_range(0, 3);
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      case (rx_mode)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= 1'($urandom_range(0, 1));
        2:       out_ready_i <= ($urandom_range(0, 3) == 0);
        default: out_ready_i <= rx_tick[2];
      endcase
    end
  end

  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 4'd10) return 8'("0" + v);
    if ($urandom_range(0, 1)) return 8'("A" + v - 10);
    return 8'("a" + v - 10);
  endfunction

  function automatic void push_hex_byte(logic [7:0] b);
    text_buf.push_back(hex_char(b[7:4]));
    text_buf.push_back(hex_char(b[3:0]));
  endfunction

  // well formed serial number text with random dots, case and crc form
  function automatic void build_serial();
    logic [7:0] b;
    logic [7:0] sum;
    int         pattern;
    text_buf.delete();
    sum     = '0;
    pattern = $urandom_range(0, 9);
    for (int k = 0; k < 7; k++) begin
      b = (pattern == 0) ? 8'h00 : (pattern == 1) ? 8'hFF : 8'($urandom);
      push_hex_byte(b);
      sum = rom_id_checker::crc_step(sum, b);
      if (k == 0 && $urandom_range(0, 1)) text_buf.push_back(".");
    end
    if ($urandom_range(0, 1)) text_buf.push_back(".");
    case ($urandom_range(0, 2))
      0:       ;
      1:       push_hex_byte(sum);
      default: push_hex_byte(sum ^ 8'($urandom_range(1, 255)));
    endcase
  endfunction

  // damage a well formed string in one of several ways
  function automatic void break_serial();
    int pos;
    pos = $urandom_range(0, text_buf.size() - 1);
    case ($urandom_range(0, 3))
      0: begin
        pos = $urandom_range(1, text_buf.size() - 1);
        while (text_buf.size() > pos) void'(text_buf.pop_back());
      end
      1: text_buf[pos] = 8'($urandom_range(0, 255));
      2: begin
        repeat ($urandom_range(1, 3)) begin
          case ($urandom_range(0, 2))
            0:       text_buf.push_back(".");
            1:       text_buf.push_back(hex_char(4'($urandom)));
            default: text_buf.push_back(8'($urandom));
          endcase
        end
      end
      default: text_buf.insert(pos, ".");
    endcase
  endfunction

  function automatic void build_noise(int max_len);
    text_buf.delete();
    repeat ($urandom_range(1, max_len)) begin
      case ($urandom_range(0, 3))
        0:       text_buf.push_back(".");
        1:       text_buf.push_back(hex_char(4'($urandom)));
        default: text_buf.push_back(8'($urandom_range(0, 255)));
      endcase
    end
  endfunction

  // one input beat; called and returns at a falling edge
  task automatic send_char(logic [7:0] c, logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      case ($urandom_range(0, 3))
        0:       gap = 0;
        1:       gap = $urandom_range(20, 40);
        default: gap = $urandom_range(1, 5);
      endcase
      if (gap > 0) begin
        in_valid_i  <= 1'b0;
        char_code_i <= 8'($urandom);
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i  <= 1'b1;
    char_code_i <= c;
    last_char_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    chars_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text();
    for (int i = 0; i < text_buf.size(); i++)
      send_char(text_buf[i], i == text_buf.size() - 1);
  endtask

  task automatic send_literal(string s);
    text_buf.delete();
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    send_text();
  endtask

  // hold input until every predicted result has been taken
  task automatic drain_results();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(negedge clk_i);
    while (board.pending() != 0) @(negedge clk_i);
  endtask

  initial begin
    logic held;
    int   kind;
    held = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: bytes 00 and FF, early end, error then ignored chars, trailing dot
    text_buf = '{8'h00};
    send_text();
    text_buf = '{8'hFF};
    send_text();
    send_literal("9");
    send_literal("0g1");
    send_literal("fA.0123456789Ab.");

    // random strings, mostly well formed
    while (chars_sent < TEXT_CHARS) begin
      if (!held && chars_sent >= TEXT_CHARS / 2) begin
        held = 1'b1;
        holdoff_asked++;
        repeat (20) begin
          build_noise(2);
          send_text();
        end
        drain_results();
      end
      kind = $urandom_range(0, 9);
      if (kind < 9) begin
        build_serial();
        if (kind >= 7) break_serial();
      end else begin
        build_noise(20);
      end
      send_text();
    end

    drain_results();
    repeat (4) @(posedge clk_i);
    $display("summary: %0d strings in %0d chars; %0d valid, %0d bad format, %0d crc mismatch",
             board.strings, board.chars, board.n_valid, board.n_format, board.n_mismatch);
    $display("summary: one long output hold-off and drain pauses, %0d errors", board.errors);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/owrid_pkg.sv
hdl/onewire_rom_id_text_parser_core.sv
dv/tb_onewire_rom_id_text_parser_core.sv
